// ===== hw/rtl/point_to_plane_residual_jacobian_macros.svh =====
// ----------------------------------------------------------------------------
// point-to-plane residual assertion macros
// Concurrent check macros that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_PLANE_RESIDUAL_JACOBIAN_MACROS_SVH
`define POINT_TO_PLANE_RESIDUAL_JACOBIAN_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define P2PL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define P2PL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define P2PL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define P2PL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/p2pl_pkg.sv =====
// ----------------------------------------------------------------------------
// p2pl_pkg
// Constants, register codes and fixed-point helpers for the residual block.
// ----------------------------------------------------------------------------
package p2pl_pkg;

  localparam int NUM_STG = 9;

  // configuration register codes
  localparam logic [2:0] REG_TRANS_X = 3'd0;
  localparam logic [2:0] REG_TRANS_Y = 3'd1;
  localparam logic [2:0] REG_TRANS_Z = 3'd2;
  localparam logic [2:0] REG_QUAT_X  = 3'd3;
  localparam logic [2:0] REG_QUAT_Y  = 3'd4;
  localparam logic [2:0] REG_QUAT_Z  = 3'd5;
  localparam logic [2:0] REG_QUAT_W  = 3'd6;
  localparam logic [2:0] REG_INFO    = 3'd7;

  localparam logic signed [31:0] QUAT_W_RST = 32'sd1073741824;
  localparam logic [31:0]        INFO_RST   = 32'd65536;
  localparam logic signed [35:0] ONE_Q30    = 36'sd1073741824;

  localparam logic [4:0] SH_Q16 = 5'd16;
  localparam logic [4:0] SH_Q30 = 5'd30;

  typedef logic signed [31:0] word_t;
  typedef logic signed [91:0] prod_t;

  // a*b / 2^30, truncated toward zero
  function automatic logic signed [49:0] mul30(input logic signed [39:0] a,
                                               input logic signed [39:0] b);
    logic signed [79:0] prd;
    logic signed [79:0] bias;
    prd  = 80'(a) * 80'(b);
    bias = prd[79] ? 80'sh3FFF_FFFF : 80'sd0;
    mul30 = 50'((prd + bias) >>> 30);
  endfunction

  // x / 2^sh toward zero, then clamp to the 32-bit signed range
  function automatic word_t sat_trunc(input prod_t x, input logic [4:0] sh);
    prod_t bias;
    prod_t q;
    word_t res;
    bias = x[91] ? ((92'sd1 <<< sh) - 92'sd1) : 92'sd0;
    q    = (x + bias) >>> sh;
    if (q > 92'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (q < -92'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = word_t'(q[31:0]);
    end
    sat_trunc = res;
  endfunction

endpackage

// ===== hw/rtl/point_to_plane_residual_jacobian.sv =====
// ----------------------------------------------------------------------------
// point_to_plane_residual_jacobian
// Moves a body-frame point by the configured pose and returns the weighted
// plane residual with its translation and rotation Jacobians.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | point, normal, offset, weight
//  out     | output    | out_valid / out_ready| residual, jac_trans, jac_rot
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// nine register stages, one word per cycle unless out_ready stalls a full
// pipeline; the depth comes from the multiply, add and truncate chain.
// synchronous reset clears stage valids and loads the pose defaults.
// each stage holds its word while the stage after it is full and stalled,
// so bubbles are squeezed out and in_ready drops only when all are full.
// cfg_ready is always high.
`include "point_to_plane_residual_jacobian_macros.svh"

module point_to_plane_residual_jacobian import p2pl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_normal_x,
  input  logic signed [31:0] in_normal_y,
  input  logic signed [31:0] in_normal_z,
  input  logic signed [31:0] in_plane_offset,
  input  logic [31:0]        in_factor_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_residual,
  output logic signed [31:0] out_jac_trans_x,
  output logic signed [31:0] out_jac_trans_y,
  output logic signed [31:0] out_jac_trans_z,
  output logic signed [31:0] out_jac_rot_x,
  output logic signed [31:0] out_jac_rot_y,
  output logic signed [31:0] out_jac_rot_z
);

  // pose registers
  word_t       trans_r [3];
  word_t       quat_r  [4];   // x, y, z, w
  logic [31:0] info_r;

  logic [NUM_STG-1:0] stg_v_r;
  logic [NUM_STG-1:0] stg_adv;

  // stage data
  word_t              p0_r [3], p1_r [3], p2_r [3], p3_r [3];
  word_t              n0_r [3], n1_r [3], n2_r [3], n3_r [3], n4_r [3], n5_r [3];
  word_t              off0_r, off1_r, off2_r, off3_r, off4_r;
  logic [47:0]        sw0_r, sw1_r, sw2_r, sw3_r, sw4_r, sw5_r;
  logic signed [33:0] qq0_r  [9];  // xx yy zz xy xz yz wx wy wz
  logic signed [35:0] rot1_r [9];
  logic signed [35:0] rot_nxt [9];
  logic signed [37:0] rp2_r  [9];
  logic signed [37:0] nr2_r  [9];
  logic signed [39:0] pw3_r  [3];
  logic signed [39:0] v3_r   [3];
  logic signed [40:0] npw4_r [3];
  logic signed [40:0] vp4_r  [6];
  logic signed [42:0] d5_r;
  logic signed [41:0] nu5_r  [3];
  logic signed [42:0] opnd   [7];
  logic signed [67:0] ph6_r  [7];
  logic signed [67:0] pl6_r  [7];
  prod_t              pr7_r  [7];
  word_t              res8_r [7];

  logic signed [31:0] qa [9];
  logic signed [31:0] qb [9];
  logic [63:0]        sw_prod;
  logic signed [35:0] qsum [9];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
      quat_r[0]  <= '0;
      quat_r[1]  <= '0;
      quat_r[2]  <= '0;
      quat_r[3]  <= QUAT_W_RST;
      info_r     <= INFO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRANS_X: trans_r[0] <= word_t'(cfg_data);
        REG_TRANS_Y: trans_r[1] <= word_t'(cfg_data);
        REG_TRANS_Z: trans_r[2] <= word_t'(cfg_data);
        REG_QUAT_X:  quat_r[0]  <= word_t'(cfg_data);
        REG_QUAT_Y:  quat_r[1]  <= word_t'(cfg_data);
        REG_QUAT_Z:  quat_r[2]  <= word_t'(cfg_data);
        REG_QUAT_W:  quat_r[3]  <= word_t'(cfg_data);
        REG_INFO:    info_r     <= cfg_data;
      endcase
    end
  end

  // a stage advances when it is empty or the next one advances
  always_comb begin
    stg_adv[NUM_STG-1] = !stg_v_r[NUM_STG-1] || out_ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      stg_adv[k] = !stg_v_r[k] || stg_adv[k+1];
    end
  end

  assign in_ready = stg_adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      if (stg_adv[0]) begin
        stg_v_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (stg_adv[k]) begin
          stg_v_r[k] <= stg_v_r[k-1];
        end
      end
    end
  end

  // quaternion product operands
  always_comb begin
    qa[0] = quat_r[0]; qb[0] = quat_r[0];
    qa[1] = quat_r[1]; qb[1] = quat_r[1];
    qa[2] = quat_r[2]; qb[2] = quat_r[2];
    qa[3] = quat_r[0]; qb[3] = quat_r[1];
    qa[4] = quat_r[0]; qb[4] = quat_r[2];
    qa[5] = quat_r[1]; qb[5] = quat_r[2];
    qa[6] = quat_r[3]; qb[6] = quat_r[0];
    qa[7] = quat_r[3]; qb[7] = quat_r[1];
    qa[8] = quat_r[3]; qb[8] = quat_r[2];
  end

  assign sw_prod = 64'(info_r) * 64'(in_factor_weight);

  // rotation matrix from the quaternion products
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      qsum[k] = '0;
    end
    qsum[0] = 36'(qq0_r[1]) + 36'(qq0_r[2]);
    qsum[1] = 36'(qq0_r[3]) - 36'(qq0_r[8]);
    qsum[2] = 36'(qq0_r[4]) + 36'(qq0_r[7]);
    qsum[3] = 36'(qq0_r[3]) + 36'(qq0_r[8]);
    qsum[4] = 36'(qq0_r[0]) + 36'(qq0_r[2]);
    qsum[5] = 36'(qq0_r[5]) - 36'(qq0_r[6]);
    qsum[6] = 36'(qq0_r[4]) - 36'(qq0_r[7]);
    qsum[7] = 36'(qq0_r[5]) + 36'(qq0_r[6]);
    qsum[8] = 36'(qq0_r[0]) + 36'(qq0_r[1]);
    for (int k = 0; k < 9; k++) begin
      if (k == 0 || k == 4 || k == 8) begin
        rot_nxt[k] = ONE_Q30 - (qsum[k] <<< 1);
      end else begin
        rot_nxt[k] = qsum[k] <<< 1;
      end
    end
  end

  // wide products split on the scale: d, n and -u against sw
  always_comb begin
    opnd[0] = d5_r;
    for (int i = 0; i < 3; i++) begin
      opnd[1+i] = 43'(n5_r[i]);
      opnd[4+i] = 43'(nu5_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv[0]) begin
      p0_r[0] <= in_point_x;
      p0_r[1] <= in_point_y;
      p0_r[2] <= in_point_z;
      n0_r[0] <= in_normal_x;
      n0_r[1] <= in_normal_y;
      n0_r[2] <= in_normal_z;
      off0_r  <= in_plane_offset;
      sw0_r   <= sw_prod[63:16];
      for (int k = 0; k < 9; k++) begin
        qq0_r[k] <= 34'(mul30(40'(qa[k]), 40'(qb[k])));
      end
    end
    if (stg_adv[1]) begin
      p1_r   <= p0_r;
      n1_r   <= n0_r;
      off1_r <= off0_r;
      sw1_r  <= sw0_r;
      rot1_r <= rot_nxt;
    end
    if (stg_adv[2]) begin
      p2_r   <= p1_r;
      n2_r   <= n1_r;
      off2_r <= off1_r;
      sw2_r  <= sw1_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rp2_r[i*3+j] <= 38'(mul30(40'(rot1_r[i*3+j]), 40'(p1_r[j])));
          nr2_r[i*3+j] <= 38'(mul30(40'(n1_r[i]), 40'(rot1_r[i*3+j])));
        end
      end
    end
    if (stg_adv[3]) begin
      p3_r   <= p2_r;
      n3_r   <= n2_r;
      off3_r <= off2_r;
      sw3_r  <= sw2_r;
      for (int i = 0; i < 3; i++) begin
        pw3_r[i] <= 40'(trans_r[i]) + 40'(rp2_r[i*3]) + 40'(rp2_r[i*3+1])
                    + 40'(rp2_r[i*3+2]);
        v3_r[i]  <= 40'(nr2_r[i]) + 40'(nr2_r[3+i]) + 40'(nr2_r[6+i]);
      end
    end
    if (stg_adv[4]) begin
      n4_r   <= n3_r;
      off4_r <= off3_r;
      sw4_r  <= sw3_r;
      for (int i = 0; i < 3; i++) begin
        npw4_r[i] <= 41'(mul30(40'(n3_r[i]), pw3_r[i]));
      end
      vp4_r[0] <= 41'(mul30(v3_r[1], 40'(p3_r[2])));
      vp4_r[1] <= 41'(mul30(v3_r[2], 40'(p3_r[1])));
      vp4_r[2] <= 41'(mul30(v3_r[2], 40'(p3_r[0])));
      vp4_r[3] <= 41'(mul30(v3_r[0], 40'(p3_r[2])));
      vp4_r[4] <= 41'(mul30(v3_r[0], 40'(p3_r[1])));
      vp4_r[5] <= 41'(mul30(v3_r[1], 40'(p3_r[0])));
    end
    if (stg_adv[5]) begin
      n5_r  <= n4_r;
      sw5_r <= sw4_r;
      d5_r  <= 43'(off4_r) + 43'(npw4_r[0]) + 43'(npw4_r[1]) + 43'(npw4_r[2]);
      // negated cross product, so the rotation terms need no later negate
      nu5_r[0] <= 42'(vp4_r[1]) - 42'(vp4_r[0]);
      nu5_r[1] <= 42'(vp4_r[3]) - 42'(vp4_r[2]);
      nu5_r[2] <= 42'(vp4_r[5]) - 42'(vp4_r[4]);
    end
    if (stg_adv[6]) begin
      for (int k = 0; k < 7; k++) begin
        ph6_r[k] <= 68'($signed({1'b0, sw5_r[47:24]})) * 68'(opnd[k]);
        pl6_r[k] <= 68'($signed({1'b0, sw5_r[23:0]})) * 68'(opnd[k]);
      end
    end
    if (stg_adv[7]) begin
      for (int k = 0; k < 7; k++) begin
        pr7_r[k] <= (prod_t'(ph6_r[k]) <<< 24) + prod_t'(pl6_r[k]);
      end
    end
    if (stg_adv[8]) begin
      for (int k = 0; k < 7; k++) begin
        if (k >= 1 && k <= 3) begin
          res8_r[k] <= sat_trunc(pr7_r[k], SH_Q30);
        end else begin
          res8_r[k] <= sat_trunc(pr7_r[k], SH_Q16);
        end
      end
    end
  end

  assign out_valid       = stg_v_r[NUM_STG-1];
  assign out_residual    = res8_r[0];
  assign out_jac_trans_x = res8_r[1];
  assign out_jac_trans_y = res8_r[2];
  assign out_jac_trans_z = res8_r[3];
  assign out_jac_rot_x   = res8_r[4];
  assign out_jac_rot_y   = res8_r[5];
  assign out_jac_rot_z   = res8_r[6];

  `P2PL_ASSERT_NXT(a_in_enters, clk, rst_n, in_valid && in_ready, stg_v_r[0], "accepted word lost at entry")
  `P2PL_ASSERT_NXT(a_mid_holds, clk, rst_n, stg_v_r[4] && !stg_adv[4], stg_v_r[4], "stalled word dropped")
  `P2PL_ASSERT_NXT(a_no_repeat, clk, rst_n, out_valid && out_ready && !stg_v_r[NUM_STG-2], !out_valid, "result repeated")

endmodule
